// ===== src/tcge_pkg.sv =====
// ----------------------------------------------------------------------------
// tcge_pkg: shared types and constants
// Request, result and internal command formats of the cursor-motion expander.
// ----------------------------------------------------------------------------
package tcge_pkg;

  localparam int unsigned ValueWidthDef = 16;
  localparam int unsigned QueueDepthDef = 4;

  // decimal printing: magnitude never exceeds 999999
  localparam int unsigned MagW       = 20;
  localparam int unsigned MaxDigits  = 6;
  localparam int unsigned DigIdxW    = 3;
  localparam int unsigned Recip10    = 838861;  // ceil(2^23 / 10)
  localparam int unsigned RecipShift = 23;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2d;

  typedef struct packed {
    logic [7:0]         cap_char;
    logic signed [15:0] row_in;
    logic signed [15:0] col_in;
    logic               start_mark;
    logic               end_mark;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       done_res;
    logic       error;
  } res_t;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_DEC  = 2'd1,
    CMD_DONE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [7:0]      data;
    logic            err;
    logic            neg;
    logic [MagW-1:0] mag;
    logic [1:0]      min_w;
  } cmd_t;

endpackage

// ===== src/tcge_front.sv =====
// ----------------------------------------------------------------------------
// tcge_front: capability string parser
// Takes requests, tracks the escape state and the operands, and issues one
// output command per request at most.
// ----------------------------------------------------------------------------
module tcge_front #(
  parameter int unsigned ValueWidth = tcge_pkg::ValueWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcge_pkg::req_t  in_req_i,
  input  logic            q_full_i,
  output logic            push_o,
  output tcge_pkg::cmd_t  cmd_o
);
  import tcge_pkg::*;

  localparam int unsigned ProdW       = ValueWidth + 32;
  localparam logic [31:0] Recip10W    = 32'hcccccccd;  // ceil(2^35 / 10)
  localparam int unsigned RecipShiftW = 35;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChN     = 8'h6e;
  localparam logic [7:0] ChBcd   = 8'h42;
  localparam logic [7:0] ChRev   = 8'h44;

  typedef enum logic [5:0] {
    MODE_PLAIN = 6'b000001,
    MODE_PCT   = 6'b000010,
    MODE_PLUS  = 6'b000100,
    MODE_GT1   = 6'b001000,
    MODE_GT2   = 6'b010000,
    MODE_DIV   = 6'b100000
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [ValueWidth-1:0]  row_q, row_d, col_q, col_d;
  logic                   tic_q, tic_d;
  logic [7:0]             cmp_q, cmp_d;
  logic                   err_q, err_d;
  logic [ValueWidth-1:0]  dvd_q, dvd_d;
  logic                   dneg_q, dneg_d;

  logic accept;

  assign in_ready_o = (mode_q != MODE_DIV) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [ValueWidth-1:0]        row_w, col_w, tgt, tnew, mag_t, r4x, quo, qs;
    logic                         tic_w, err_w, tneg, sneg;
    mode_e                        mode_w;
    logic [7:0]                   cmp_w, c;
    logic [ProdW-1:0]             prod;
    logic signed [31:0]           s_ext, s_sat, s_mag;
    logic signed [31:0]           row_ext, col_ext;

    mode_d = mode_q;
    row_d  = row_q;
    col_d  = col_q;
    tic_d  = tic_q;
    cmp_d  = cmp_q;
    err_d  = err_q;
    dvd_d  = dvd_q;
    dneg_d = dneg_q;
    push_o = 1'b0;
    cmd_o  = '0;

    row_w  = row_q;
    col_w  = col_q;
    tic_w  = tic_q;
    err_w  = err_q;
    mode_w = mode_q;
    cmp_w  = cmp_q;
    c      = in_req_i.cap_char;
    tgt    = '0;
    tnew   = '0;
    mag_t  = '0;
    r4x    = '0;
    quo    = '0;
    qs     = '0;
    tneg   = 1'b0;
    sneg   = 1'b0;
    prod   = '0;
    s_ext  = '0;
    s_sat  = '0;
    s_mag  = '0;
    row_ext = 32'(in_req_i.row_in);
    col_ext = 32'(in_req_i.col_in);

    if (mode_q == MODE_DIV) begin
      // magnitude over ten by reciprocal multiplication
      prod = ProdW'(dvd_q) * ProdW'(Recip10W);
      quo  = ValueWidth'(prod >> RecipShiftW);
      qs   = dneg_q ? (~quo + ValueWidth'(1)) : quo;
      tgt  = tic_q ? col_q : row_q;
      tnew = tgt + (qs << 2) + (qs << 1);
      if (tic_q) col_d = tnew;
      else       row_d = tnew;
      mode_d = MODE_PLAIN;
    end else if (accept) begin
      if (in_req_i.start_mark) begin
        row_w  = row_ext[ValueWidth-1:0];
        col_w  = col_ext[ValueWidth-1:0];
        mode_w = MODE_PLAIN;
        tic_w  = 1'b0;
        cmp_w  = '0;
        err_w  = 1'b0;
      end
      tgt  = tic_w ? col_w : row_w;
      tneg = tgt[ValueWidth-1];
      mag_t = tneg ? (~tgt + ValueWidth'(1)) : tgt;

      if (in_req_i.end_mark) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_DONE;
        cmd_o.err  = err_w || (mode_w != MODE_PLAIN);
        mode_w     = MODE_PLAIN;
        err_w      = 1'b0;
        tic_w      = 1'b0;
      end else if (!err_w) begin
        case (mode_w)
          MODE_PCT: begin
            mode_w = MODE_PLAIN;
            case (c)
              ChD, ChTwo, ChThree: begin
                s_ext = 32'(signed'(tgt));
                s_sat = s_ext;
                if (s_ext > 32'sd999999) s_sat = 32'sd999999;
                if (s_ext < -32'sd99999) s_sat = -32'sd99999;
                sneg  = s_sat[31];
                s_mag = sneg ? -s_sat : s_sat;
                push_o      = 1'b1;
                cmd_o.kind  = CMD_DEC;
                cmd_o.neg   = sneg;
                cmd_o.mag   = s_mag[MagW-1:0];
                cmd_o.min_w = (c == ChD) ? 2'd1 : ((c == ChTwo) ? 2'd2 : 2'd3);
                tic_w = 1'b1;
              end
              ChDot: begin
                push_o     = 1'b1;
                cmd_o.kind = CMD_BYTE;
                cmd_o.data = tgt[7:0];
                tic_w = 1'b1;
              end
              ChPlus: mode_w = MODE_PLUS;
              ChGt:   mode_w = MODE_GT1;
              ChR: begin
                row_w = col_w;
                col_w = row_d;
                if (in_req_i.start_mark) col_w = row_ext[ValueWidth-1:0];
              end
              ChI: begin
                row_w = row_w + ValueWidth'(1);
                col_w = col_w + ValueWidth'(1);
              end
              ChN: begin
                row_w = row_w ^ ValueWidth'(8'h60);
                col_w = col_w ^ ValueWidth'(8'h60);
              end
              ChBcd: begin
                dvd_d  = mag_t;
                dneg_d = tneg;
                mode_w = MODE_DIV;
              end
              ChRev: begin
                r4x  = ValueWidth'(mag_t[3:0]) << 1;
                tnew = tneg ? (tgt + r4x) : (tgt - r4x);
                if (tic_w) col_w = tnew;
                else       row_w = tnew;
              end
              ChPct: begin
                push_o     = 1'b1;
                cmd_o.kind = CMD_BYTE;
                cmd_o.data = ChPct;
              end
              default: err_w = 1'b1;
            endcase
          end
          MODE_PLUS: begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_BYTE;
            cmd_o.data = tgt[7:0] + c;
            tic_w  = 1'b1;
            mode_w = MODE_PLAIN;
          end
          MODE_GT1: begin
            cmp_w  = c;
            mode_w = MODE_GT2;
          end
          MODE_GT2: begin
            if (signed'(tgt) > signed'(ValueWidth'({1'b0, cmp_w}))) begin
              tnew = tgt + ValueWidth'(c);
              if (tic_w) col_w = tnew;
              else       row_w = tnew;
            end
            mode_w = MODE_PLAIN;
          end
          default: begin
            mode_w = MODE_PLAIN;
            if (c == ChPct) begin
              mode_w = MODE_PCT;
            end else begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_BYTE;
              cmd_o.data = c;
            end
          end
        endcase
      end

      mode_d = mode_w;
      row_d  = row_w;
      col_d  = col_w;
      tic_d  = tic_w;
      cmp_d  = cmp_w;
      err_d  = err_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      row_q  <= '0;
      col_q  <= '0;
      tic_q  <= 1'b0;
      cmp_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      row_q  <= row_d;
      col_q  <= col_d;
      tic_q  <= tic_d;
      cmp_q  <= cmp_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dneg_q <= dneg_d;
  end

endmodule

// ===== src/tcge_queue.sv =====
// ----------------------------------------------------------------------------
// tcge_queue: command queue
// Small first-word-fall-through queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module tcge_queue #(
  parameter int unsigned QueueDepth = tcge_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcge_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tcge_pkg::cmd_t cmd_o
);
  import tcge_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ===== src/tcge_back.sv =====
// ----------------------------------------------------------------------------
// tcge_back: byte emitter
// Executes queued commands: passes bytes and terminators on; prints decimals
// into a registered result stage one digit per cycle unless output stalls.
// ----------------------------------------------------------------------------
module tcge_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tcge_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcge_pkg::res_t out_res_o
);
  import tcge_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam int unsigned ProdW = 2 * MagW;

  state_e             st_q, st_d;
  logic               ov_q, ov_d;
  res_t               res_q, res_d;
  logic [MagW-1:0]    mag_q, mag_d;
  logic               sign_q, sign_d;
  logic [1:0]         minw_q, minw_d;
  logic [1:0]         pad_q, pad_d;
  logic [DigIdxW-1:0] nd_q, nd_d;
  logic [3:0]         dig_q [MaxDigits];
  logic               dig_we;
  logic [3:0]         dig_wd;

  logic               out_free;
  logic [ProdW-1:0]   prod;
  logic [MagW-1:0]    quo;
  logic [MagW-1:0]    rem_full;
  logic [DigIdxW-1:0] rd_idx;

  assign out_free    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  assign prod     = ProdW'(mag_q) * ProdW'(Recip10);
  assign quo      = MagW'(prod >> RecipShift);
  assign rem_full = mag_q - ((quo << 3) + (quo << 1));
  assign rd_idx   = nd_q - DigIdxW'(1);

  always_comb begin
    logic [1:0]         need_w;
    logic [DigIdxW-1:0] nd_n;

    st_d   = st_q;
    ov_d   = ov_q && !out_ready_i;
    res_d  = res_q;
    mag_d  = mag_q;
    sign_d = sign_q;
    minw_d = minw_q;
    pad_d  = pad_q;
    nd_d   = nd_q;
    pop_o  = 1'b0;
    dig_we = 1'b0;
    dig_wd = rem_full[3:0];
    need_w = '0;
    nd_n   = nd_q + DigIdxW'(1);

    case (st_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_BYTE: begin
              ov_d  = 1'b1;
              res_d = '{out_byte: cmd_i.data, done_res: 1'b0, error: 1'b0};
            end
            CMD_DONE: begin
              ov_d  = 1'b1;
              res_d = '{out_byte: 8'h00, done_res: 1'b1, error: cmd_i.err};
            end
            CMD_DEC: begin
              mag_d  = cmd_i.mag;
              sign_d = cmd_i.neg;
              minw_d = cmd_i.min_w;
              nd_d   = '0;
              st_d   = ST_CONV;
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        dig_we = 1'b1;
        mag_d  = quo;
        nd_d   = nd_n;
        if (quo == '0 || nd_n == DigIdxW'(MaxDigits)) begin
          need_w = minw_q - 2'(sign_q);
          pad_d  = (DigIdxW'(need_w) > nd_n) ? 2'(DigIdxW'(need_w) - nd_n) : 2'd0;
          st_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;
          res_d.done_res = 1'b0;
          res_d.error    = 1'b0;
          if (sign_q) begin
            res_d.out_byte = ChMinus;
            sign_d = 1'b0;
          end else if (pad_q != 2'd0) begin
            res_d.out_byte = ChZero;
            pad_d = pad_q - 2'd1;
          end else begin
            res_d.out_byte = ChZero + 8'(dig_q[rd_idx]);
            nd_d = rd_idx;
            if (nd_q == DigIdxW'(1)) st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    mag_q  <= mag_d;
    sign_q <= sign_d;
    minw_q <= minw_d;
    pad_q  <= pad_d;
    nd_q   <= nd_d;
    if (dig_we) dig_q[nd_q] <= dig_wd;
  end

endmodule

// ===== src/termcap_cursor_goto_expander_core.sv =====
// ----------------------------------------------------------------------------
// termcap_cursor_goto_expander_core: cursor-motion string expander
// Expands a termcap cursor-motion capability into terminal output bytes.
// ----------------------------------------------------------------------------
// The parser takes one capability character per cycle while the queue has
// room and no %B escape is running, and queues at most one command per
// request; a %B escape holds the input while its multiply by the reciprocal
// of ten runs. The emitter sends one result per cycle, while the output is
// not stalled, for plain bytes, %%, %., %+ and terminators. A printed decimal
// is taken from the queue, converted digit by digit in the divide-by-ten unit
// and then sent byte by byte. The command queue lets the parser run ahead
// while the emitter is busy or the output is stalled.
module termcap_cursor_goto_expander_core #(
  parameter int unsigned ValueWidth = tcge_pkg::ValueWidthDef,
  parameter int unsigned QueueDepth = tcge_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcge_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcge_pkg::res_t out_res_o
);
  import tcge_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t cmd_in, cmd_out;

  tcge_front #(
    .ValueWidth(ValueWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (cmd_in)
  );

  tcge_queue #(
    .QueueDepth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (cmd_out)
  );

  tcge_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (cmd_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

// ===== src/tcge_checker.sv =====
// ----------------------------------------------------------------------------
// tcge_port_checks: port-level checks
// Watches the request and result channels of the expander core.
// ----------------------------------------------------------------------------
module tcge_port_checks (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input tcge_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input tcge_pkg::res_t out_res_o
);
  import tcge_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("waiting request changed");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> out_res_o.out_byte == 8'h00)
    else $error("terminator carries a byte");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.error |-> out_res_o.done_res)
    else $error("error flag on a byte result");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result pending straight after reset");

endmodule

bind termcap_cursor_goto_expander_core tcge_port_checks u_tcge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

// ===== verif/tcge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcge_checker: expansion scoreboard for the cursor-motion expander
// Follows every accepted request with its own copy of the expander state and
// checks each accepted result, in order, against the predicted bytes.
// ----------------------------------------------------------------------------
module tcge_checker
  import tcge_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  res_t out_res_i,
  output int   fails_o,
  output int   pending_o
);

  localparam logic [7:0] EscDec  = "d";
  localparam logic [7:0] EscDec2 = "2";
  localparam logic [7:0] EscDec3 = "3";
  localparam logic [7:0] EscRaw  = ".";
  localparam logic [7:0] EscPlus = "+";
  localparam logic [7:0] EscGt   = ">";
  localparam logic [7:0] EscSwap = "r";
  localparam logic [7:0] EscInc  = "i";
  localparam logic [7:0] EscXor  = "n";
  localparam logic [7:0] EscBcd  = "B";
  localparam logic [7:0] EscRev  = "D";
  localparam logic [7:0] EscPct  = "%";

  localparam logic [15:0] XorMask = 16'o140;

  typedef enum logic [2:0] {
    ModePlain,
    ModePct,
    ModePlus,
    ModeGt1,
    ModeGt2
  } mode_e;

  mode_e       mode;
  logic [15:0] row_q;
  logic [15:0] col_q;
  logic        on_col;
  logic [7:0]  cmp_char;
  logic        err_seen;
  res_t        expansion_q[$];
  int          fails;

  function automatic void emit_byte(logic [7:0] b);
    res_t r;
    r.out_byte = b;
    r.done_res = 1'b0;
    r.error    = 1'b0;
    expansion_q.push_back(r);
  endfunction

  function automatic logic [15:0] target();
    return on_col ? col_q : row_q;
  endfunction

  function automatic void set_target(int v);
    if (on_col) begin
      col_q = v[15:0];
    end else begin
      row_q = v[15:0];
    end
  endfunction

  // sign counts towards the minimum width
  function automatic void emit_decimal(int v, int w);
    logic [7:0] dig[8];
    bit         neg;
    int         mag;
    int         nd;
    int         total;
    neg = v < 0;
    mag = neg ? -v : v;
    nd  = 0;
    do begin
      dig[nd] = ChZero + 8'(mag % 10);
      mag     = mag / 10;
      nd++;
    end while (mag != 0);
    total = nd;
    if (total < w - int'(neg)) begin
      total = w - int'(neg);
    end
    if (neg) begin
      emit_byte(ChMinus);
    end
    for (int i = total; i > nd; i--) begin
      emit_byte(ChZero);
    end
    for (int i = nd; i > 0; i--) begin
      emit_byte(dig[i-1]);
    end
  endfunction

  function automatic void apply_escape(logic [7:0] c);
    int          t;
    logic [15:0] tmp;
    t    = $signed(target());
    mode = ModePlain;
    case (c)
      EscDec: begin
        emit_decimal(t, 1);
        on_col = 1'b1;
      end
      EscDec2: begin
        emit_decimal(t, 2);
        on_col = 1'b1;
      end
      EscDec3: begin
        emit_decimal(t, 3);
        on_col = 1'b1;
      end
      EscRaw: begin
        emit_byte(t[7:0]);
        on_col = 1'b1;
      end
      EscPlus: mode = ModePlus;
      EscGt:   mode = ModeGt1;
      EscSwap: begin
        tmp   = row_q;
        row_q = col_q;
        col_q = tmp;
      end
      EscInc: begin
        row_q = row_q + 16'd1;
        col_q = col_q + 16'd1;
      end
      EscXor: begin
        row_q = row_q ^ XorMask;
        col_q = col_q ^ XorMask;
      end
      EscBcd:  set_target(t + 6 * (t / 10));
      EscRev:  set_target(t - 2 * (t % 16));
      EscPct:  emit_byte(EscPct);
      default: err_seen = 1'b1;
    endcase
  endfunction

  function automatic void expand_request(req_t r);
    res_t term;
    int   t;
    int   x;
    if (r.start_mark) begin
      mode     = ModePlain;
      row_q    = r.row_in;
      col_q    = r.col_in;
      on_col   = 1'b0;
      cmp_char = 8'd0;
      err_seen = 1'b0;
    end
    if (r.end_mark) begin
      term.out_byte = 8'd0;
      term.done_res = 1'b1;
      term.error    = err_seen | (mode != ModePlain);
      expansion_q.push_back(term);
      mode     = ModePlain;
      err_seen = 1'b0;
      on_col   = 1'b0;
      return;
    end
    if (err_seen) begin
      return;
    end
    case (mode)
      ModePct: apply_escape(r.cap_char);
      ModePlus: begin
        t = $signed(target());
        emit_byte(t[7:0] + r.cap_char);
        on_col = 1'b1;
        mode   = ModePlain;
      end
      ModeGt1: begin
        cmp_char = r.cap_char;
        mode     = ModeGt2;
      end
      ModeGt2: begin
        t = $signed(target());
        x = int'(cmp_char);
        if (t > x) begin
          set_target(t + int'(r.cap_char));
        end
        mode = ModePlain;
      end
      default: begin
        if (r.cap_char == EscPct) begin
          mode = ModePct;
        end else begin
          emit_byte(r.cap_char);
        end
      end
    endcase
  endfunction

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    bit   bad;
    if (!rst_ni) begin
      mode     = ModePlain;
      row_q    = '0;
      col_q    = '0;
      on_col   = 1'b0;
      cmp_char = '0;
      err_seen = 1'b0;
      expansion_q.delete();
      fails_o   <= fails;
      pending_o <= 0;
    end else begin
      // results first: nothing accepted at this edge can already be on the output
      if (out_valid_i && out_ready_i) begin
        if (expansion_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %h done %b error %b",
                   $time, out_res_i.out_byte, out_res_i.done_res, out_res_i.error);
          fails++;
        end else begin
          want = expansion_q.pop_front();
          bad  = 1'b0;
          if (out_res_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h got %h",
                     $time, want.out_byte, out_res_i.out_byte);
            bad = 1'b1;
          end
          if (out_res_i.done_res !== want.done_res) begin
            $display("%0t: done_res expected %b got %b",
                     $time, want.done_res, out_res_i.done_res);
            bad = 1'b1;
          end
          if (out_res_i.error !== want.error) begin
            $display("%0t: error expected %b got %b", $time, want.error, out_res_i.error);
            bad = 1'b1;
          end
          if (bad) begin
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expand_request(in_req_i);
      end
      fails_o   <= fails;
      pending_o <= expansion_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: cursor-motion expander testbench
// Directed capability strings for every escape and error case, then random
// strings, mostly well formed, with random gaps on both sides and a long
// output stall. Checking is done by tcge_checker.
// ----------------------------------------------------------------------------
module tb;
  import tcge_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam string      SimpleOps  = "d23.rinBD%";
  localparam string      AllOps     = "d23.+>rinBD%";
  localparam logic [7:0] Introducer = "%";

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_res_o;
  int   fails;
  int   pending;
  bit   steady;
  bit   hold_req;
  int   items;

  termcap_cursor_goto_expander_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  tcge_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_i   (out_res_o),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic text_t chars(string t);
    text_t q;
    for (int i = 0; i < t.len(); i++) begin
      q.push_back(t[i]);
    end
    return q;
  endfunction

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      1:       return 16'($urandom_range(0, 140)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // random string, about one in ten broken by a bad or unfinished escape
  function automatic text_t make_text();
    text_t      s;
    logic [7:0] c;
    bit         known;
    int         ntok;
    ntok = $urandom_range(1, 5);
    for (int k = 0; k < ntok; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          do c = rand_byte(); while (c == Introducer);
          s.push_back(c);
        end
        3: begin
          s = {s, chars("%+")};
          s.push_back(rand_byte());
        end
        4: begin
          s = {s, chars("%>")};
          s.push_back(8'($urandom_range(0, 130)));
          s.push_back(rand_byte());
        end
        default: begin
          s.push_back(Introducer);
          s.push_back(SimpleOps[$urandom_range(0, SimpleOps.len() - 1)]);
        end
      endcase
    end
    case ($urandom_range(0, 19))
      0: begin
        do begin
          c     = rand_byte();
          known = 1'b0;
          for (int i = 0; i < AllOps.len(); i++) begin
            if (AllOps[i] == c) begin
              known = 1'b1;
            end
          end
        end while (known);
        s.push_back(Introducer);
        s.push_back(c);
        s.push_back(rand_byte());
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       s.push_back(Introducer);
          1:       s = {s, chars("%+")};
          2:       s = {s, chars("%>")};
          default: begin
            s = {s, chars("%>")};
            s.push_back(rand_byte());
          end
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic push_req(input req_t r);
    bit hit;
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do begin
      @(negedge clk_i);
      hit = in_ready_o;
      @(posedge clk_i);
    end while (!hit);
    items++;
  endtask

  // one string: start mark on the first request if load is set, then the terminator
  task automatic send_text(input logic signed [15:0] row, input logic signed [15:0] col,
                           input bit load, input text_t s);
    req_t r;
    for (int i = 0; i <= s.size(); i++) begin
      r.row_in     = (i == 0) ? row : 16'($urandom);
      r.col_in     = (i == 0) ? col : 16'($urandom);
      r.start_mark = load && (i == 0);
      r.end_mark   = (i == s.size());
      r.cap_char   = r.end_mark ? 8'($urandom) : s[i];
      push_req(r);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  initial begin
    text_t s;
    bit    load;
    bit    held;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    held        = 1'b0;
    items       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both marks on one request, then extreme operands printed
    s.delete();
    send_text(16'sh8000, 16'sh7fff, 1'b1, s);
    send_text(16'sh8000, 16'sh7fff, 1'b1, chars("%d%3"));
    s = chars("%2%.");
    s.push_back(8'h00);
    send_text(-16'sd5, 16'sd511, 1'b1, s);
    // carries on from the previous operands
    s = chars("%r%i%n%+");
    s.push_back(8'hff);
    s = {s, chars("%>")};
    s.push_back(8'h00);
    s.push_back(8'h07);
    send_text(16'sd0, 16'sd0, 1'b0, s);
    s = chars("%B%D%>");
    s.push_back(8'h00);
    s.push_back(8'hff);
    s = {s, chars("%%%d%3")};
    send_text(16'sd37, 16'sh8000, 1'b1, s);
    send_text(-16'sd1, -16'sd1, 1'b1, chars("%q!"));
    send_text(16'sd1, 16'sd1, 1'b1, chars("%"));

    while (items < 470) begin
      if (items >= 180 && !held) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      steady = (items >= 320 && items < 380);
      case ($urandom_range(0, 19))
        0: begin
          s.delete();
          load = 1'b1;
        end
        1: begin
          s    = make_text();
          load = 1'b0;
        end
        default: begin
          s    = make_text();
          load = 1'b1;
        end
      endcase
      send_text(rand_val(), rand_val(), load, s);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
